/* rtl/dedup_drop_oldest_fifo_core_macros.svh */
// Assertion macros shared by the RTL. They compile away under SYNTHESIS.
`ifndef DEDUP_DROP_OLDEST_FIFO_CORE_MACROS_SVH
`define DEDUP_DROP_OLDEST_FIFO_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define DDOF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("ddof assertion failed");
`define DDOF_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("ddof assertion failed");
`else
`define DDOF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`define DDOF_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/ddof_pkg.sv */
package ddof_pkg;

	localparam int DEF_QUEUE_DEPTH = 8;
	localparam int DEF_CODE_COUNT  = 16;
	localparam int CODE_W          = 8;

	typedef enum logic [1:0] {
		FN_SUBMIT = 2'd0,
		FN_TAKE   = 2'd1,
		FN_FLUSH  = 2'd2
	} func_t;

	typedef enum logic [2:0] {
		ST_QUEUED    = 3'd0,
		ST_DROPPED   = 3'd1,
		ST_DUPLICATE = 3'd2,
		ST_INVALID   = 3'd3,
		ST_TAKEN     = 3'd4,
		ST_EMPTY     = 3'd5,
		ST_FLUSHED   = 3'd6
	} status_t;

endpackage

/* rtl/ddof_slot_ram.sv */
module ddof_slot_ram
	import ddof_pkg::*;
#(
	parameter int DEPTH  = DEF_QUEUE_DEPTH,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [CODE_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [CODE_W-1:0] rd_data
);

	logic [CODE_W-1:0] mem [DEPTH];
	logic [CODE_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

/* rtl/dedup_drop_oldest_fifo_core.sv */
// An operation first reads the oldest slot from the slot RAM, then updates the
// pointers, writes the RAM and registers the result.
// done pulses for one cycle, registered from busy after the transfer; busy is high in between.
// A new operation is taken only while busy is low, not before the last one is through; the receiver cannot stall.
// arst_n clears pointers, fill count and handshake state; slot contents stay unknown.
`include "dedup_drop_oldest_fifo_core_macros.svh"

module dedup_drop_oldest_fifo_core
	import ddof_pkg::*;
#(
	parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
	parameter int CODE_COUNT  = DEF_CODE_COUNT,
	parameter int PTR_W       = $clog2(QUEUE_DEPTH),
	parameter int CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [1:0]        func,
	input  logic [CODE_W-1:0] code_in,
	output logic              done,
	output logic [2:0]        status,
	output logic [CODE_W-1:0] code_out,
	output logic [CNT_W-1:0]  pending
);

	localparam logic [CODE_W-1:0] CODE_LIMIT = CODE_W'(CODE_COUNT);
	localparam logic [CNT_W-1:0]  FULL_CNT   = CNT_W'(QUEUE_DEPTH);
	localparam logic [PTR_W-1:0]  LAST_PTR   = PTR_W'(QUEUE_DEPTH - 1);

	logic              accept;
	logic              busy_q;
	logic [1:0]        func_s1;
	logic [CODE_W-1:0] code_s1;

	logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
	logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
	logic [CNT_W-1:0]  fill_q, fill_d;
	logic [CODE_W-1:0] newest_q;
	logic [CODE_W-1:0] rd_data;

	logic              wr_en;
	status_t           st_d;
	logic [CODE_W-1:0] code_d;

	logic              done_q;
	status_t           status_q;
	logic [CODE_W-1:0] code_out_q;
	logic [CNT_W-1:0]  pending_q;

	assign accept = start && !busy_q;

	// The oldest slot is read on every transfer; only take and drop use it.
	ddof_slot_ram #(
		.DEPTH  (QUEUE_DEPTH),
		.ADDR_W (PTR_W)
	) u_slot_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_ptr_q),
		.wr_data (code_s1),
		.rd_en   (accept),
		.rd_addr (rd_ptr_q),
		.rd_data (rd_data)
	);

	function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
		ring_next = (p == LAST_PTR) ? '0 : p + 1'b1;
	endfunction

	always_comb begin
		rd_ptr_d = rd_ptr_q;
		wr_ptr_d = wr_ptr_q;
		fill_d   = fill_q;
		wr_en    = 1'b0;
		st_d     = ST_INVALID;
		code_d   = '0;
		unique case (func_t'(func_s1))
			FN_SUBMIT: begin
				if (code_s1 >= CODE_LIMIT) begin
					st_d = ST_INVALID;
				end else if (fill_q != '0 && newest_q == code_s1) begin
					st_d = ST_DUPLICATE;
				end else begin
					wr_en    = 1'b1;
					wr_ptr_d = ring_next(wr_ptr_q);
					if (fill_q == FULL_CNT) begin
						// Full: the oldest entry leaves and the count stays the same.
						st_d     = ST_DROPPED;
						code_d   = rd_data;
						rd_ptr_d = ring_next(rd_ptr_q);
					end else begin
						st_d   = ST_QUEUED;
						fill_d = fill_q + 1'b1;
					end
				end
			end
			FN_TAKE: begin
				if (fill_q == '0) begin
					st_d = ST_EMPTY;
				end else begin
					st_d     = ST_TAKEN;
					code_d   = rd_data;
					rd_ptr_d = ring_next(rd_ptr_q);
					fill_d   = fill_q - 1'b1;
				end
			end
			FN_FLUSH: begin
				st_d     = ST_FLUSHED;
				rd_ptr_d = '0;
				wr_ptr_d = '0;
				fill_d   = '0;
			end
			default: begin
				st_d = ST_INVALID;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			done_q   <= 1'b0;
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			done_q <= busy_q;
			if (accept) begin
				busy_q <= 1'b1;
			end else if (busy_q) begin
				busy_q   <= 1'b0;
				rd_ptr_q <= rd_ptr_d;
				wr_ptr_q <= wr_ptr_d;
				fill_q   <= fill_d;
			end
		end
	end

	// Payload registers; meaningful only alongside busy_q or done_q.
	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1 <= func;
			code_s1 <= code_in;
		end
		if (busy_q) begin
			status_q   <= st_d;
			code_out_q <= code_d;
			pending_q  <= fill_d;
			if (wr_en) begin
				newest_q <= code_s1;
			end
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign status   = status_q;
	assign code_out = code_out_q;
	assign pending  = pending_q;

	`DDOF_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy && !done)
	`DDOF_ASSERT_NEXT(a_busy_done, clk, arst_n, busy, done && !busy)
	`DDOF_ASSERT_SAME(a_fill_bound, clk, arst_n, 1'b1, fill_q <= FULL_CNT)
	`DDOF_ASSERT_SAME(a_empty_zero, clk, arst_n, done && status_q == ST_EMPTY,
		pending == '0 && code_out == '0)

endmodule
